/* sv/ptq_pkg.sv */
// shared types and constants of the periodic timer queue
`default_nettype none

package ptq_pkg;

   // table size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths of the words
   localparam int OP_W   = 2;
   localparam int TIME_W = 63;
   localparam int ID_W   = 31;
   localparam int TAG_W  = 16;
   localparam int STAT_W = 2;
   localparam int RC_W   = 9;
   localparam int KEY_W  = TIME_W + ID_W;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   // request word
   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] time_ns;
      logic [TIME_W-1:0] interval_ns;
      logic [TAG_W-1:0]  cmd_tag;
      logic [ID_W-1:0]   target_id;
   } req_type;

   // response word
   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   entry_id;
      logic [RC_W-1:0]   removed_count;
      logic [TAG_W-1:0]  fired_tag;
      logic [TIME_W-1:0] fired_time_ns;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [TIME_W-1:0] time_ns;
      logic [TIME_W-1:0] interval_ns;
      logic [TAG_W-1:0]  tag;
      logic [ID_W-1:0]   id;
   } slot_type;

   // write command from the sequencer to the table
   typedef struct packed {
      logic             append;
      logic             clear;
      logic             remove;
      logic             rearm;
      logic [IDX_W-1:0] idx;
      slot_type         entry;
   } store_cmd_type;

   // operands of the shared compare and add unit
   typedef struct packed {
      logic [KEY_W-1:0]  key_a;
      logic [KEY_W-1:0]  key_b;
      logic [TIME_W-1:0] add_a;
      logic [TIME_W-1:0] add_b;
   } alu_op_type;

   // results of the shared compare and add unit
   typedef struct packed {
      logic              lt;
      logic              eq;
      logic [TIME_W-1:0] sum;
   } alu_res_type;

endpackage

`default_nettype wire

/* sv/ptq_alu.sv */
// shared key comparator and saturating time adder
`default_nettype none

module ptq_alu import ptq_pkg::*; (
   input  alu_op_type  alu_op,
   output alu_res_type alu_res
);

   logic [TIME_W:0] sum_full;

   // key compare: time in the upper bits, id in the lower bits
   assign alu_res.lt = (alu_op.key_a < alu_op.key_b);
   assign alu_res.eq = (alu_op.key_a == alu_op.key_b);

   // re-arm add, clamped at the largest time
   assign sum_full    = {1'b0, alu_op.add_a} + {1'b0, alu_op.add_b};
   assign alu_res.sum = sum_full[TIME_W] ? {TIME_W{1'b1}} : sum_full[TIME_W-1:0];

endmodule

`default_nettype wire

/* sv/ptq_store.sv */
// entry table: entries packed from slot zero up in insertion order
`default_nettype none

module ptq_store import ptq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  store_cmd_type    cmd,
   input  logic [IDX_W-1:0] rd_idx,
   output slot_type         rd_slot,
   output logic [CNT_W-1:0] count
);

   slot_type         slot_ff [CAPACITY];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // fill count
   always_comb begin
      priority if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // per slot write: append at the end, re-arm in place, or shift down on removal
   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      localparam int UP = (i < CAPACITY - 1) ? i + 1 : i;

      always_ff @(posedge clock) begin
         if (cmd.append && (count_ff == CNT_W'(i))) begin
            slot_ff[i] <= cmd.entry;
         end else if (cmd.rearm && (cmd.idx == IDX_W'(i))) begin
            slot_ff[i].time_ns <= cmd.entry.time_ns;
         end else if (cmd.remove && (cmd.idx <= IDX_W'(i))) begin
            slot_ff[i] <= slot_ff[UP];
         end
      end
   end

   // scan read port
   assign rd_slot = slot_ff[rd_idx];
   assign count   = count_ff;

endmodule

`default_nettype wire

/* sv/ptq_seq.sv */
// sequencer: walks the table one slot a cycle and issues table writes
`default_nettype none

module ptq_seq import ptq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_word,
   output logic             busy,
   input  logic             out_free,
   output logic             done,
   output rsp_type          result,
   output store_cmd_type    cmd,
   output logic [IDX_W-1:0] rd_idx,
   input  slot_type         rd_slot,
   input  logic [CNT_W-1:0] count,
   output alu_op_type       alu_op,
   input  alu_res_type      alu_res
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_CHECK = 5'b00100,
      S_APPLY = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   slot_type         best_ff, best_in;
   rsp_type          res_ff, res_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         next_id_ff <= '0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
   end

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      next_id_in  = next_id_ff;
      cmd         = '0;
      alu_op      = '0;
      alu_op.add_a = best_ff.time_ns;
      alu_op.add_b = best_ff.interval_ns;
      done        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               idx_in = '0;
               res_in = '0;
               if ((req_word.op == OP_ADD) || (req_word.op == OP_CLEAR)) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // remove compares ids, pop compares time then id against the best so far
            if (req_ff.op == OP_REMOVE) begin
               alu_op.key_a = {{TIME_W{1'b0}}, rd_slot.id};
               alu_op.key_b = {{TIME_W{1'b0}}, req_ff.target_id};
            end else begin
               alu_op.key_a = {rd_slot.time_ns, rd_slot.id};
               alu_op.key_b = {best_ff.time_ns, best_ff.id};
            end

            if (idx_ff == count) begin
               if ((req_ff.op == OP_POP) && (count != '0)) begin
                  state_in = S_CHECK;
               end else begin
                  res_in.status = ST_MISS;
                  state_in      = S_DONE;
               end
            end else if (req_ff.op == OP_REMOVE) begin
               if (alu_res.eq) begin
                  state_in = S_APPLY;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end else begin
               if ((idx_ff == '0) || alu_res.lt) begin
                  best_in     = rd_slot;
                  best_idx_in = idx_ff[IDX_W-1:0];
               end
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         S_CHECK: begin
            // earliest entry overall is due when its time is at or before now
            alu_op.key_a = {best_ff.time_ns, {ID_W{1'b0}}};
            alu_op.key_b = {req_ff.time_ns, {ID_W{1'b1}}};
            if (alu_res.lt) begin
               state_in = S_APPLY;
            end else begin
               res_in.status = ST_MISS;
               state_in      = S_DONE;
            end
         end

         S_APPLY: begin
            unique case (req_ff.op)
               OP_ADD: begin
                  if (count == CNT_W'(CAPACITY)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     cmd.append            = 1'b1;
                     cmd.entry.time_ns     = req_ff.time_ns;
                     cmd.entry.interval_ns = req_ff.interval_ns;
                     cmd.entry.tag         = req_ff.cmd_tag;
                     cmd.entry.id          = next_id_ff;
                     res_in.entry_id       = next_id_ff;
                     next_id_in            = next_id_ff + ID_W'(1);
                  end
               end
               OP_CLEAR: begin
                  cmd.clear            = 1'b1;
                  res_in.removed_count = RC_W'(count);
               end
               OP_REMOVE: begin
                  cmd.remove           = 1'b1;
                  cmd.idx              = idx_ff[IDX_W-1:0];
                  res_in.removed_count = RC_W'(1);
               end
               OP_POP: begin
                  res_in.entry_id      = best_ff.id;
                  res_in.fired_tag     = best_ff.tag;
                  res_in.fired_time_ns = best_ff.time_ns;
                  cmd.idx              = best_idx_ff;
                  if (best_ff.interval_ns != '0) begin
                     cmd.rearm         = 1'b1;
                     cmd.entry.time_ns = alu_res.sum;
                  end else begin
                     cmd.remove = 1'b1;
                  end
               end
               default: begin
                  res_in.status = ST_MISS;
               end
            endcase
            state_in = S_DONE;
         end

         S_DONE: begin
            done = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_idx = idx_ff[IDX_W-1:0];
   assign busy   = (state_ff != S_IDLE);
   assign result = res_ff;

endmodule

`default_nettype wire

/* sv/periodic_timer_queue.sv */
// top level of the periodic timer queue
`default_nettype none

// Table of up to CAPACITY timer entries (due time, period, tag, id). One request
// word is taken when the block is idle; the block then stalls its request side
// until that word's response is registered. The response register lets a new
// request in while the previous response still waits. A single key comparator
// visits one stored entry per cycle: add and remove-all go straight to the
// table write, remove by id scans until the id matches (a miss when none does),
// and pop scans all stored entries, then checks that the earliest one is due (a
// miss when it is not, or when the table is empty).
module periodic_timer_queue import ptq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic             busy;
   logic             out_free;
   logic             done;
   rsp_type          result;
   store_cmd_type    cmd;
   logic [IDX_W-1:0] rd_idx;
   slot_type         rd_slot;
   logic [CNT_W-1:0] count;
   alu_op_type       alu_op;
   alu_res_type      alu_res;
   logic             rsp_valid_ff;
   rsp_type          rsp_word_ff;

   // sequencer
   ptq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .busy      (busy),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .rd_slot   (rd_slot),
      .count     (count),
      .alu_op    (alu_op),
      .alu_res   (alu_res)
   );

   // entry table
   ptq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_idx  (rd_idx),
      .rd_slot (rd_slot),
      .count   (count)
   );

   // shared compare and add unit
   ptq_alu u_alu (
      .alu_op  (alu_op),
      .alu_res (alu_res)
   );

   // response register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_word_ff <= result;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* sv/ptq_checker.sv */
// port checker for the periodic timer queue and its bind
`default_nettype none

module ptq_checker import ptq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_word,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);

   // an accepted request keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after accept");

   // a full report carries no id and no removal count
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == ST_FULL)) |->
      ((rsp_word.entry_id == '0) && (rsp_word.removed_count == '0)))
      else $error("full status with nonzero fields");

   // removal count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.removed_count <= RC_W'(CAPACITY)))
      else $error("removed count above capacity");

   // a miss reports nothing fired
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == ST_MISS)) |->
      ((rsp_word.fired_tag == '0) && (rsp_word.fired_time_ns == '0)))
      else $error("miss status with fired fields");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response changed");

endmodule

bind periodic_timer_queue ptq_checker u_ptq_checker (.*);

`default_nettype wire
